### sv/sps_pkg.sv
// Package: constants, types and helper functions for the pattern search block.
package sps_pkg;
  localparam int PatternDepth = 64;
  localparam int TextDepth = 64;
  localparam int PAW = $clog2(PatternDepth);
  localparam int TAW = $clog2(TextDepth);
  localparam int PLW = PAW + 1;
  localparam int TLW = TAW + 1;
  localparam int POS_W = 6;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_LOW = 8'h61;
  localparam logic [7:0] CH_UP = 8'h41;
  localparam logic [7:0] CH_BAR = 8'h7C;
  localparam logic [7:0] CH_HAT = 8'h5E;

  typedef enum logic [1:0] {
    CMD_PAT  = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_FIND = 2'd2,
    CMD_CLR  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a command
    S_START,  // issue reads for a new start position
    S_ELEM,   // pattern element and text char arrive
    S_ESC,    // second char of an escape arrives
    S_CLS0,   // first char after an opening bar arrives
    S_CLS,    // class list char arrives
    S_NEXT,   // advance start position
    S_OUT     // result waits for transfer
  } state_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_lower(c) || is_upper(c);
  endfunction
endpackage

### sv/sps_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
module sps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/simple_pattern_search.sv
// Top level: pattern and text stores plus the sequencer that walks them during a search.
// Load and clear commands return no result.
// A search walks the stores one pattern character per cycle through the read
// port of each RAM, from a start state for each start position tried, and ends
// in the result register state; the block takes no item meanwhile.
// Synchronous active-low reset clears both lengths and the dropped flag; the
// store contents are left undefined and are never read beyond the lengths.
module simple_pattern_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] command, [9:2] symbol, zero fill above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] found, [6:1] position, [7] overflow
);
  import sps_pkg::*;

  state_t state_r, state_nxt;
  logic [PLW-1:0] plen_r, plen_nxt;
  logic [TLW-1:0] tlen_r, tlen_nxt;
  logic drop_r, drop_nxt;
  logic [TLW-1:0] start_r, start_nxt;
  logic [PLW-1:0] p_r, p_nxt;     // index of char now arriving from pattern RAM
  logic [TLW-1:0] t_r, t_nxt;     // index of text char being matched
  logic neg_r, neg_nxt, hit_r, hit_nxt;
  logic found_r, found_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [1:0] cmd;
  logic [7:0] sym;
  logic acc;
  logic [7:0] pch, tch;
  logic [PAW-1:0] praddr;
  logic [TAW-1:0] traddr;
  logic pwe, twe;

  assign cmd = in_tdata[1:0];
  assign sym = in_tdata[9:2];
  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign pwe = acc && (cmd == CMD_PAT) && (plen_r < PLW'(PatternDepth));
  assign twe = acc && (cmd == CMD_TEXT) && (tlen_r < TLW'(TextDepth));

  sps_ram #(.Width(8), .Depth(PatternDepth)) u_pat (
    .clk(clk), .we(pwe), .waddr(plen_r[PAW-1:0]), .wdata(sym),
    .raddr(praddr), .rdata(pch)
  );
  sps_ram #(.Width(8), .Depth(TextDepth)) u_txt (
    .clk(clk), .we(twe), .waddr(tlen_r[TAW-1:0]), .wdata(sym),
    .raddr(traddr), .rdata(tch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plen_r <= '0;
      tlen_r <= '0;
      drop_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      plen_r <= plen_nxt;
      tlen_r <= tlen_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    p_r <= p_nxt;
    t_r <= t_nxt;
    neg_r <= neg_nxt;
    hit_r <= hit_nxt;
    found_r <= found_nxt;
    pos_r <= pos_nxt;
  end

  // Next state and datapath of the search sequencer.
  always_comb begin
    state_nxt = state_r;
    plen_nxt = plen_r;
    tlen_nxt = tlen_r;
    drop_nxt = drop_r;
    start_nxt = start_r;
    p_nxt = p_r;
    t_nxt = t_r;
    neg_nxt = neg_r;
    hit_nxt = hit_r;
    found_nxt = found_r;
    pos_nxt = pos_r;
    praddr = p_r[PAW-1:0];
    traddr = t_r[TAW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd)
            CMD_PAT: begin
              if (pwe) plen_nxt = plen_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            CMD_TEXT: begin
              if (twe) tlen_nxt = tlen_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            CMD_FIND: begin
              found_nxt = 1'b0;
              pos_nxt = '0;
              start_nxt = '0;
              state_nxt = (tlen_r == '0) ? S_OUT : S_START;
            end
            default: begin
              plen_nxt = '0;
              tlen_nxt = '0;
              drop_nxt = 1'b0;
            end
          endcase
        end
      end
      S_START: begin
        if (plen_r == '0) begin
          found_nxt = 1'b1;
          pos_nxt = start_r[POS_W-1:0];
          state_nxt = S_OUT;
        end else begin
          praddr = '0;
          traddr = start_r[TAW-1:0];
          p_nxt = '0;
          t_nxt = start_r;
          state_nxt = S_ELEM;
        end
      end
      S_ELEM: begin
        // pch = pattern[p], tch = text[t]; t < tlen and p < plen hold here.
        state_nxt = S_NEXT;
        if (is_letter(pch)) begin
          if (pch == tch) p_nxt = p_r + 1'b1;
        end else if (pch == CH_DOT) begin
          p_nxt = p_r + 1'b1;
        end else if (pch == CH_BSL) begin
          if (p_r + 1'b1 < plen_r) begin
            praddr = PAW'(p_r + 1'b1);
            p_nxt = p_r + 1'b1;
            state_nxt = S_ESC;
          end
        end else if (pch == CH_BAR) begin
          if (p_r + 1'b1 < plen_r) begin
            praddr = PAW'(p_r + 1'b1);
            p_nxt = p_r + 1'b1;
            neg_nxt = 1'b0;
            hit_nxt = 1'b0;
            state_nxt = S_CLS0;
          end
        end
        // A consumed one-char element reports a match if it was the last element, else moves on while text is left.
        if (state_nxt == S_NEXT && p_nxt != p_r) begin
          if (p_nxt == plen_r) begin
            found_nxt = 1'b1;
            pos_nxt = start_r[POS_W-1:0];
            state_nxt = S_OUT;
          end else if (t_r + 1'b1 < tlen_r) begin
            t_nxt = t_r + 1'b1;
            praddr = p_nxt[PAW-1:0];
            traddr = TAW'(t_r + 1'b1);
            state_nxt = S_ELEM;
          end
        end
      end
      S_ESC: begin
        state_nxt = S_NEXT;
        if ((pch == CH_LOW && is_lower(tch)) || (pch == CH_UP && is_upper(tch))) begin
          p_nxt = p_r + 1'b1;
          if (p_nxt == plen_r) begin
            found_nxt = 1'b1;
            pos_nxt = start_r[POS_W-1:0];
            state_nxt = S_OUT;
          end else if (t_r + 1'b1 < tlen_r) begin
            t_nxt = t_r + 1'b1;
            praddr = p_nxt[PAW-1:0];
            traddr = TAW'(t_r + 1'b1);
            state_nxt = S_ELEM;
          end
        end
      end
      S_CLS0, S_CLS: begin
        state_nxt = S_NEXT;
        if (state_r == S_CLS0 && pch == CH_HAT) begin
          neg_nxt = 1'b1;
          if (p_r + 1'b1 < plen_r) begin
            p_nxt = p_r + 1'b1;
            praddr = PAW'(p_r + 1'b1);
            state_nxt = S_CLS;
          end
        end else if (is_letter(pch)) begin
          if (pch == tch) hit_nxt = 1'b1;
          if (p_r + 1'b1 < plen_r) begin
            p_nxt = p_r + 1'b1;
            praddr = PAW'(p_r + 1'b1);
            state_nxt = S_CLS;
          end
        end else if (pch == CH_BAR && hit_r != neg_r) begin
          p_nxt = p_r + 1'b1;
          if (p_nxt == plen_r) begin
            found_nxt = 1'b1;
            pos_nxt = start_r[POS_W-1:0];
            state_nxt = S_OUT;
          end else if (t_r + 1'b1 < tlen_r) begin
            t_nxt = t_r + 1'b1;
            praddr = p_nxt[PAW-1:0];
            traddr = TAW'(t_r + 1'b1);
            state_nxt = S_ELEM;
          end
        end
      end
      S_NEXT: begin
        if (start_r + 1'b1 < tlen_r) begin
          start_nxt = start_r + 1'b1;
          state_nxt = S_START;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid = (state_r == S_OUT);
    out_tdata = {drop_r, pos_r, found_r};
  end
endmodule

### verif/sps_checker.sv
// Checker for the pattern search block: predicts each search result and compares it.
`timescale 1ns / 1ps

module sps_checker
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          pending_count
);

  logic [7:0] pat_mem [PatternDepth];
  logic [7:0] txt_mem [TextDepth];
  int         pat_len;
  int         txt_len;
  logic       dropped;
  logic [7:0] expected_results[$];

  function automatic logic lower_ch(logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic logic upper_ch(logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  // Tries the whole pattern against the text from one start position.
  function automatic logic match_from(int start);
    int p, t, q;
    logic [7:0] e, c, n;
    logic negate, hit;
    p = 0;
    t = start;
    while (p < pat_len) begin
      if (t >= txt_len) return 1'b0;
      c = txt_mem[t];
      e = pat_mem[p];
      if (lower_ch(e) || upper_ch(e)) begin
        if (e != c) return 1'b0;
        p++;
      end else if (e == CH_DOT) begin
        p++;
      end else if (e == CH_BSL) begin
        if (p + 1 >= pat_len) return 1'b0;
        n = pat_mem[p+1];
        if (n == CH_LOW) begin
          if (!lower_ch(c)) return 1'b0;
        end else if (n == CH_UP) begin
          if (!upper_ch(c)) return 1'b0;
        end else begin
          return 1'b0;
        end
        p += 2;
      end else if (e == CH_BAR) begin
        q = p + 1;
        negate = 1'b0;
        hit = 1'b0;
        if (q < pat_len && pat_mem[q] == CH_HAT) begin
          negate = 1'b1;
          q++;
        end
        while (q < pat_len && (lower_ch(pat_mem[q]) || upper_ch(pat_mem[q]))) begin
          if (pat_mem[q] == c) hit = 1'b1;
          q++;
        end
        if (q >= pat_len || pat_mem[q] != CH_BAR) return 1'b0;
        if (hit == negate) return 1'b0;
        p = q + 1;
      end else begin
        return 1'b0;
      end
      t++;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] search_result();
    logic [7:0] r;
    r = {dropped, 7'd0};
    for (int s = 0; s < txt_len; s++) begin
      if (match_from(s)) begin
        r[0] = 1'b1;
        r[6:1] = s[5:0];
        break;
      end
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    cmd_t       cmd;
    logic [7:0] sym;
    logic [7:0] exp_r;
    if (!rst_n) begin
      pat_len = 0;
      txt_len = 0;
      dropped = 1'b0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r != out_tdata) begin
            $display("%0t: mismatch expected found=%0d pos=%0d ovf=%0d,",
                     $time, exp_r[0], exp_r[6:1], exp_r[7],
                     " actual found=%0d pos=%0d ovf=%0d",
                     out_tdata[0], out_tdata[6:1], out_tdata[7]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        cmd = cmd_t'(in_tdata[1:0]);
        sym = in_tdata[9:2];
        case (cmd)
          CMD_PAT: begin
            if (pat_len < PatternDepth) begin
              pat_mem[pat_len] = sym;
              pat_len = pat_len + 1;
            end else begin
              dropped = 1'b1;
            end
          end
          CMD_TEXT: begin
            if (txt_len < TextDepth) begin
              txt_mem[txt_len] = sym;
              txt_len = txt_len + 1;
            end else begin
              dropped = 1'b1;
            end
          end
          CMD_FIND: expected_results.push_back(search_result());
          default: begin
            pat_len = 0;
            txt_len = 0;
            dropped = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

### verif/testbench.sv
// Testbench top: drives commands into the pattern search block and gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import sps_pkg::*;

  localparam int IDLE_PCT = 14;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  int          fail_count;
  int          pending_count;
  logic        hold_output;
  logic        calm;
  int          quiet_cycles;

  simple_pattern_search u_dut (.*);

  sps_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, unless held off or in the calm stretch.
  always @(negedge clk) begin
    if (hold_output) out_tready <= 1'b0;
    else if (calm) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("simple_pattern_search verification failed");
        $finish;
      end
    end
  end

  // Offers one command, with an optional random gap before it, until a transfer.
  // Ready is checked in the low clock phase, where it is stable until the next edge.
  task automatic send_cmd(cmd_t cmd, logic [7:0] sym);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'd0, sym, cmd};
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata = 16'($urandom_range(65535));
  endtask

  task automatic load_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_cmd(CMD_PAT, s[i]);
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) send_cmd(CMD_TEXT, s[i]);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
                             : 8'(8'h41 + $urandom_range(25));
  endfunction

  // Picks a pattern element, mostly well formed, sometimes noise.
  function automatic logic [7:0] pattern_char(logic [7:0] prev);
    int r;
    r = $urandom_range(99);
    if (prev == CH_BSL) return (r < 45) ? CH_LOW : (r < 90) ? CH_UP : 8'($urandom_range(255));
    if (r < 55) return 8'(8'h61 + $urandom_range(3));
    if (r < 65) return CH_DOT;
    if (r < 73) return CH_BSL;
    if (r < 83) return CH_BAR;
    if (r < 88) return CH_HAT;
    if (r < 93) return random_letter();
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int plen, tlen;
    logic [7:0] prev;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 16'd0;
    hold_output = 1'b0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty text, empty pattern, letters, classes, escapes, bad forms.
    send_cmd(CMD_FIND, 8'hFF);
    load_text("xAbc");
    send_cmd(CMD_FIND, 8'h00);
    load_pattern("b.");
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_CLR, 8'h00);
    load_text("Qz");
    load_pattern("\\A\\a");
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_CLR, 8'h00);
    load_text("mk");
    load_pattern("|^m|");
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_CLR, 8'h00);
    load_text("k");
    load_pattern("|^|");
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_CLR, 8'h00);
    load_text("k");
    load_pattern("||");
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_PAT, 8'h5C);
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_CLR, 8'hFF);

    // Full stores: overflow and a pattern too long to match; then a short match.
    for (int i = 0; i < TextDepth + 2; i++) send_cmd(CMD_TEXT, (i == 62) ? 8'h5A : 8'h61);
    for (int i = 0; i < PatternDepth + 1; i++) send_cmd(CMD_PAT, (i == 0) ? 8'h5A : 8'h2E);
    send_cmd(CMD_FIND, 8'h00);
    send_cmd(CMD_CLR, 8'h00);
    load_text("aaZa");
    load_pattern("Za");
    send_cmd(CMD_FIND, 8'h00);

    // Long receiver hold-off while the sender keeps offering searches.
    fork
      begin
        @(negedge clk);
        hold_output = 1'b1;
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
      end
      repeat (6) send_cmd(CMD_FIND, 8'h00);
    join
    wait_drained();

    // Random sequences: clear, load text and pattern, then search.
    for (int n = 0; n < 12; n++) begin
      calm = (n >= 4 && n < 8);
      if (n == 9) wait_drained();
      send_cmd(CMD_CLR, 8'($urandom_range(255)));
      tlen = ($urandom_range(9) == 0) ? $urandom_range(64, 70) : $urandom_range(0, 12);
      for (int i = 0; i < tlen; i++) begin
        send_cmd(CMD_TEXT, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                    : 8'(8'h61 + $urandom_range(3)));
      end
      plen = ($urandom_range(19) == 0) ? $urandom_range(64, 66) : $urandom_range(0, 5);
      prev = 8'h00;
      for (int i = 0; i < plen; i++) begin
        prev = pattern_char(prev);
        send_cmd(CMD_PAT, prev);
      end
      repeat ($urandom_range(1, 2)) send_cmd(CMD_FIND, 8'($urandom_range(255)));
    end
    calm = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simple_pattern_search verification clean");
    end else begin
      $display("simple_pattern_search verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sps_pkg.sv
sv/sps_ram.sv
sv/simple_pattern_search.sv
verif/sps_checker.sv
verif/testbench.sv
